// ===== rtl/sat_pkg.sv =====
// shared types, constants and microcode program of the summed-area table engine
package sat_pkg;

  localparam int IDX_W     = 7;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = 64;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 1;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // in_tdata layout
  localparam int ROW_LSB     = 0;
  localparam int COL_LSB     = ROW_LSB + IDX_W;
  localparam int ROW_END_LSB = COL_LSB + IDX_W;
  localparam int COL_END_LSB = ROW_END_LSB + IDX_W;
  localparam int VALUE_LSB   = COL_END_LSB + IDX_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_RECT  = 2'd2,
    MODE_POINT = 2'd3
  } mode_t;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_IDLE    = 4'd0;
  localparam pc_t PC_ADD_RD  = 4'd1;
  localparam pc_t PC_ADD_WR  = 4'd2;
  localparam pc_t PC_PT_RD   = 4'd3;
  localparam pc_t PC_PT_OUT  = 4'd4;
  localparam pc_t PC_RQ_A    = 4'd5;
  localparam pc_t PC_RQ_B    = 4'd6;
  localparam pc_t PC_RQ_C    = 4'd7;
  localparam pc_t PC_RQ_D    = 4'd8;
  localparam pc_t PC_RQ_OUT  = 4'd9;
  localparam pc_t PC_BL_INIT = 4'd10;
  localparam pc_t PC_BL_CUR  = 4'd11;
  localparam pc_t PC_BL_UP   = 4'd12;
  localparam pc_t PC_BL_WR   = 4'd13;
  localparam pc_t PC_DONE    = 4'd14;

  typedef enum logic [2:0] {
    AS_R1C1 = 3'd0,  // (row, col)
    AS_R2C2 = 3'd1,  // (row_end, col_end)
    AS_R0C2 = 3'd2,  // (row-1, col_end)
    AS_R2C0 = 3'd3,  // (row_end, col-1)
    AS_R0C0 = 3'd4,  // (row-1, col-1)
    AS_IJ   = 3'd5,  // build cursor
    AS_UP   = 3'd6   // entry above build cursor
  } addr_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD = 3'd0,
    ACC_LOAD = 3'd1,
    ACC_ADD  = 3'd2,
    ACC_SUB  = 3'd3,
    ACC_LMD  = 3'd4   // left minus diagonal
  } acc_op_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_ADD   = 2'd1,
    WR_BUILD = 2'd2
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INIT = 2'd1,
    CNT_STEP = 2'd2
  } cnt_op_t;

  typedef enum logic [1:0] {
    CND_NEVER  = 2'd0,
    CND_ALWAYS = 2'd1,
    CND_EMPTY  = 2'd2,
    CND_MORE   = 2'd3
  } cond_t;

  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_ACC  = 2'd1,
    EMIT_ZERO = 2'd2
  } emit_t;

  typedef struct packed {
    addr_sel_t addr_sel;
    logic      rd_en;
    acc_op_t   acc_op;
    wr_op_t    wr_op;
    cnt_op_t   cnt_op;
    cond_t     cond;
    pc_t       target;
    emit_t     emit;
  } ucode_t;

  typedef struct packed {
    mode_t mode;
    logic  err;
    logic  empty;
    logic  more;
    logic  stall;
    logic  clr_busy;
  } dp_stat_t;

  // control store
  function automatic ucode_t ucode(input pc_t pc);
    ucode_t w;
    w.addr_sel = AS_R1C1;
    w.rd_en    = 1'b0;
    w.acc_op   = ACC_HOLD;
    w.wr_op    = WR_NONE;
    w.cnt_op   = CNT_HOLD;
    w.cond     = CND_NEVER;
    w.target   = PC_IDLE;
    w.emit     = EMIT_NONE;
    case (pc)
      PC_ADD_RD: begin
        w.rd_en = 1'b1;
      end
      PC_ADD_WR: begin
        w.wr_op = WR_ADD;
        w.emit  = EMIT_ZERO;
        w.cond  = CND_ALWAYS;
      end
      PC_PT_RD: begin
        w.rd_en = 1'b1;
      end
      PC_PT_OUT: begin
        w.acc_op = ACC_LOAD;
        w.emit   = EMIT_ACC;
        w.cond   = CND_ALWAYS;
      end
      PC_RQ_A: begin
        w.addr_sel = AS_R2C2;
        w.rd_en    = 1'b1;
      end
      PC_RQ_B: begin
        w.addr_sel = AS_R0C2;
        w.rd_en    = 1'b1;
        w.acc_op   = ACC_LOAD;
      end
      PC_RQ_C: begin
        w.addr_sel = AS_R2C0;
        w.rd_en    = 1'b1;
        w.acc_op   = ACC_SUB;
      end
      PC_RQ_D: begin
        w.addr_sel = AS_R0C0;
        w.rd_en    = 1'b1;
        w.acc_op   = ACC_SUB;
      end
      PC_RQ_OUT: begin
        w.acc_op = ACC_ADD;
        w.emit   = EMIT_ACC;
        w.cond   = CND_ALWAYS;
      end
      PC_BL_INIT: begin
        w.cnt_op = CNT_INIT;
        w.cond   = CND_EMPTY;
        w.target = PC_DONE;
      end
      PC_BL_CUR: begin
        w.addr_sel = AS_IJ;
        w.rd_en    = 1'b1;
        w.acc_op   = ACC_LMD;
      end
      PC_BL_UP: begin
        w.addr_sel = AS_UP;
        w.rd_en    = 1'b1;
        w.acc_op   = ACC_ADD;
      end
      PC_BL_WR: begin
        w.addr_sel = AS_IJ;
        w.wr_op    = WR_BUILD;
        w.cnt_op   = CNT_STEP;
        w.cond     = CND_MORE;
        w.target   = PC_BL_CUR;
      end
      PC_DONE: begin
        w.emit = EMIT_ZERO;
        w.cond = CND_ALWAYS;
      end
      default: begin
        w.cond = CND_NEVER;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/sat_ram.sv =====
// generic simple dual-port ram with registered read
module sat_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sat_seq.sv =====
// microcode sequencer: step counter, control store lookup and jumps
module sat_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sat_pkg::dp_stat_t stat,
  output sat_pkg::ucode_t   ctl,
  output logic              accept
);
  import sat_pkg::*;

  pc_t  pc_r, pc_nxt;
  pc_t  entry;
  logic taken;

  assign ctl       = ucode(pc_r);
  assign in_tready = (pc_r == PC_IDLE) && !stat.clr_busy;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    case (stat.mode)
      MODE_ADD:   entry = PC_ADD_RD;
      MODE_BUILD: entry = PC_BL_INIT;
      MODE_RECT:  entry = PC_RQ_A;
      MODE_POINT: entry = PC_PT_RD;
      default:    entry = PC_DONE;
    endcase
  end

  always_comb begin
    case (ctl.cond)
      CND_ALWAYS: taken = 1'b1;
      CND_EMPTY:  taken = stat.empty;
      CND_MORE:   taken = stat.more;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    if (accept) begin
      pc_nxt = stat.err ? PC_DONE : entry;
    end else if (pc_r == PC_IDLE || stat.stall) begin
      pc_nxt = pc_r;
    end else if (taken) begin
      pc_nxt = ctl.target;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PC_DONE)
    else $error("step counter outside program");

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> pc_r != PC_IDLE)
    else $error("accepted transaction did not start a program");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.stall && !accept) |=> pc_r == $past(pc_r))
    else $error("step advanced while output stalled");
`endif

endmodule

// ===== rtl/sat_dp.sv =====
// datapath: operand latches, build cursor, accumulator, table ram, clear pass, result register
module sat_dp #(
  parameter int MAX_ROWS = sat_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = sat_pkg::DEF_MAX_COLS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [sat_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic [sat_pkg::IN_USER_W-1:0]        in_tuser,
  input  sat_pkg::idx_t                        nr,
  input  sat_pkg::idx_t                        nc,
  input  sat_pkg::ucode_t                      ctl,
  output sat_pkg::dp_stat_t                    stat,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sat_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [sat_pkg::OUT_USER_W-1:0]       out_tuser
);
  import sat_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // incoming fields
  idx_t             in_row, in_col, in_row_end, in_col_end;
  mode_t            in_mode;
  logic             in_err;

  idx_t             row_r, col_r, row_end_r, col_end_r;
  logic [VAL_W-1:0] value_r;
  logic             err_r;

  idx_t             i_r, i_nxt, j_r, j_nxt;
  logic [SUM_W-1:0] left_r, left_nxt, diag_r, diag_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;

  logic [AW-1:0]    clr_addr_r;
  logic             clr_busy_r;

  idx_t             sel_r, sel_c;
  logic             sel_zero;
  logic [AW-1:0]    mem_addr;
  logic             rd_zero_r;
  logic [SUM_W-1:0] rd_data, rd_eff, wdata;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [SUM_W-1:0] ram_wdata;

  logic             stall, emit_fire, last_col;
  logic             out_valid_r;
  logic [SUM_W-1:0] out_sum_r;
  logic             out_status_r;

  assign in_row     = in_tdata[ROW_LSB +: IDX_W];
  assign in_col     = in_tdata[COL_LSB +: IDX_W];
  assign in_row_end = in_tdata[ROW_END_LSB +: IDX_W];
  assign in_col_end = in_tdata[COL_END_LSB +: IDX_W];
  assign in_mode    = mode_t'(in_tuser[MODE_W-1:0]);

  // range check of the indices each mode uses
  always_comb begin
    case (in_mode)
      MODE_BUILD: in_err = 1'b0;
      MODE_RECT:  in_err = !((in_row != '0) && (in_row <= nr) &&
                             (in_col != '0) && (in_col <= nc) &&
                             (in_row_end != '0) && (in_row_end <= nr) &&
                             (in_col_end != '0) && (in_col_end <= nc));
      default:    in_err = !((in_row != '0) && (in_row <= nr) &&
                             (in_col != '0) && (in_col <= nc));
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_r     <= in_row;
      col_r     <= in_col;
      row_end_r <= in_row_end;
      col_end_r <= in_col_end;
      value_r   <= in_tdata[VALUE_LSB +: VAL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
    end else if (accept) begin
      err_r <= in_err;
    end
  end

  // table coordinate for the current step; index zero reads as zero
  always_comb begin
    case (ctl.addr_sel)
      AS_R1C1: begin sel_r = row_r;           sel_c = col_r;           end
      AS_R2C2: begin sel_r = row_end_r;       sel_c = col_end_r;       end
      AS_R0C2: begin sel_r = row_r - 7'd1;    sel_c = col_end_r;       end
      AS_R2C0: begin sel_r = row_end_r;       sel_c = col_r - 7'd1;    end
      AS_R0C0: begin sel_r = row_r - 7'd1;    sel_c = col_r - 7'd1;    end
      AS_IJ:   begin sel_r = i_r;             sel_c = j_r;             end
      AS_UP:   begin sel_r = i_r - 7'd1;      sel_c = j_r;             end
      default: begin sel_r = row_r;           sel_c = col_r;           end
    endcase
  end

  assign sel_zero = (sel_r == '0) || (sel_c == '0);
  assign mem_addr = sel_zero ? '0 :
                    AW'((int'(sel_r) - 1) * MAX_COLS + (int'(sel_c) - 1));

  assign stall     = (ctl.emit != EMIT_NONE) && out_valid_r && !out_tready;
  assign emit_fire = (ctl.emit != EMIT_NONE) && !stall;

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_zero_r <= sel_zero;
    end
  end

  assign rd_eff = rd_zero_r ? '0 : rd_data;

  always_comb begin
    case (ctl.wr_op)
      WR_ADD:   wdata = rd_eff + {{(SUM_W-VAL_W){value_r[VAL_W-1]}}, value_r};
      WR_BUILD: wdata = acc_r + rd_eff;
      default:  wdata = rd_eff;
    endcase
  end

  assign ram_re    = ctl.rd_en && !stall;
  assign ram_we    = clr_busy_r || ((ctl.wr_op != WR_NONE) && !stall);
  assign ram_waddr = clr_busy_r ? clr_addr_r : mem_addr;
  assign ram_wdata = clr_busy_r ? '0 : wdata;

  sat_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (mem_addr),
    .rdata (rd_data)
  );

  // zero the table once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      clr_busy_r <= (clr_addr_r != LAST_ADDR);
    end
  end

  always_comb begin
    case (ctl.acc_op)
      ACC_LOAD: acc_nxt = rd_eff;
      ACC_ADD:  acc_nxt = acc_r + rd_eff;
      ACC_SUB:  acc_nxt = acc_r - rd_eff;
      ACC_LMD:  acc_nxt = left_r - diag_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  // build cursor walks the columns of a row, then moves to the next row
  assign last_col = (j_r == nc);

  always_comb begin
    i_nxt    = i_r;
    j_nxt    = j_r;
    left_nxt = left_r;
    diag_nxt = diag_r;
    case (ctl.cnt_op)
      CNT_INIT: begin
        i_nxt    = 7'd1;
        j_nxt    = 7'd1;
        left_nxt = '0;
        diag_nxt = '0;
      end
      CNT_STEP: begin
        if (last_col) begin
          i_nxt    = i_r + 7'd1;
          j_nxt    = 7'd1;
          left_nxt = '0;
          diag_nxt = '0;
        end else begin
          j_nxt    = j_r + 7'd1;
          left_nxt = wdata;
          diag_nxt = rd_eff;
        end
      end
      default: begin
        i_nxt = i_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      acc_r  <= acc_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      left_r <= left_nxt;
      diag_r <= diag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_sum_r    <= (ctl.emit == EMIT_ACC) ? acc_nxt : '0;
      out_status_r <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_status_r;

  assign stat.mode     = in_mode;
  assign stat.err      = in_err;
  assign stat.empty    = (nr == '0) || (nc == '0);
  assign stat.more     = !(last_col && (i_r == nr));
  assign stat.stall    = stall;
  assign stat.clr_busy = clr_busy_r;

`ifndef ASSERT_OFF
  a_build_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wr_op == WR_BUILD) |->
      (i_r != '0) && (i_r <= nr) && (j_r != '0) && (j_r <= nc))
    else $error("build cursor outside table in use");

  a_emit_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit != EMIT_NONE) |-> !ctl.rd_en)
    else $error("result step overwrites read data");

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_busy_r |=> !clr_busy_r)
    else $error("clearing pass restarted");

  a_no_op_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (ctl.wr_op == WR_NONE) && !ctl.rd_en && !accept)
    else $error("table access during clearing pass");
`endif

endmodule

// ===== rtl/summed_area_table_engine.sv =====
// each transaction runs one microcode program (add, point query, rectangle query, build); an index
// error skips to the result step; a build takes three table steps per cell on the single read port
// a new transaction is taken the cycle after the previous result enters the output register
// so transactions never overlap; the table steps run one after another on the single read port
// reset: sizes go to 64, then a clearing pass zeroes all MAX_ROWS*MAX_COLS entries of the table
// with in_tready low; configuration writes are taken during the pass
module summed_area_table_engine #(
  parameter int MAX_ROWS = sat_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = sat_pkg::DEF_MAX_COLS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // row[6:0], col[13:7], row_end[20:14], col_end[27:21], value[59:28], zero fill
  input  logic [sat_pkg::IN_DATA_W-1:0]    in_tdata,
  // mode[1:0]
  input  logic [sat_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // sum[63:0]
  output logic [sat_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[0]
  output logic [sat_pkg::OUT_USER_W-1:0]   out_tuser,
  input  logic                             cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sat_pkg::CFG_W-1:0]        cfg_wdata
);
  import sat_pkg::*;

  logic [CFG_W-1:0] rows_in_use_r, cols_in_use_r;
  idx_t             nr, nc;
  dp_stat_t         stat;
  ucode_t           ctl;
  logic             accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= ROWS_RESET;
      cols_in_use_r <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: rows_in_use_r <= cfg_wdata;
        CFG_COLS: cols_in_use_r <= cfg_wdata;
        default:  rows_in_use_r <= rows_in_use_r;
      endcase
    end
  end

  // size in use saturates at the table dimensions
  assign nr = (MAX_ROWS < (1 << IDX_W) && int'(rows_in_use_r) > MAX_ROWS) ?
              IDX_W'(MAX_ROWS) : rows_in_use_r;
  assign nc = (MAX_COLS < (1 << IDX_W) && int'(cols_in_use_r) > MAX_COLS) ?
              IDX_W'(MAX_COLS) : cols_in_use_r;

  sat_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl),
    .accept    (accept)
  );

  sat_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .nr         (nr),
    .nc         (nc),
    .ctl        (ctl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
